// File: rtl/core/ps2mc_pkg.sv
// ----------------------------------------------------------------------------
// ps2mc_pkg
// Shared widths, protocol bit positions and cursor helpers for the mouse packet
// decoder.
// ----------------------------------------------------------------------------
package ps2mc_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = $clog2(MAX_DIM);
    localparam int DIM_W      = 13;
    localparam int BYTE_W     = 8;
    localparam int BTN_W      = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int SUM_W      = COORD_W + 2;

    // Header bit positions.
    localparam int BIT_LEFT   = 0;
    localparam int BIT_SYNC   = 3;
    localparam int BIT_XSIGN  = 4;
    localparam int BIT_YSIGN  = 5;
    localparam int BIT_XOVF   = 6;
    localparam int BIT_YOVF   = 7;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0]   RESET_WIDTH    = DIM_W'(1024);
    localparam logic [DIM_W-1:0]   RESET_HEIGHT   = DIM_W'(768);
    localparam logic [COORD_W-1:0] RESET_CURSOR_X = COORD_W'(1024 / 2);
    localparam logic [COORD_W-1:0] RESET_CURSOR_Y = COORD_W'(768 / 2);

    // Largest coordinate allowed by a screen size register. A size of zero
    // behaves as one column, and sizes above the maximum are capped.
    function automatic logic [COORD_W-1:0] max_coord(input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] dim_m1;
        dim_m1 = dim - DIM_W'(1);
        if (dim == '0)
        begin
            max_coord = '0;
        end
        else if (dim > DIM_W'(MAX_DIM))
        begin
            max_coord = COORD_W'(MAX_DIM - 1);
        end
        else
        begin
            max_coord = dim_m1[COORD_W-1:0];
        end
    endfunction

    // Clamp a signed candidate position into the range 0 to limit.
    function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [SUM_W-1:0] v,
                                                       input logic [COORD_W-1:0] limit);
        if (v < 0)
        begin
            clamp_coord = '0;
        end
        else if (v > $signed({2'b00, limit}))
        begin
            clamp_coord = limit;
        end
        else
        begin
            clamp_coord = v[COORD_W-1:0];
        end
    endfunction

endpackage

// File: rtl/core/ps2_mouse_packet_cursor_core.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_core
// Assembles three-byte mouse packets and keeps a clamped cursor position.
// ----------------------------------------------------------------------------
// An accepted byte's result is registered and shows on the output in the next cycle.
// Throughput: one byte per cycle unless a stalled result holds the input; the result
// register is the only stage and frees itself in the same cycle that the downstream side takes it.
// Reset: screen size 1024 by 768, cursor at its centre, buttons released,
// waiting for a header byte, no result pending.
module ps2_mouse_packet_cursor_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ps2mc_pkg::BYTE_W-1:0]        rx_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ps2mc_pkg::COORD_W-1:0]       pos_x,
    output logic [ps2mc_pkg::COORD_W-1:0]       pos_y,
    output logic [ps2mc_pkg::BTN_W-1:0]         button_bits,
    output logic                                packet_applied,
    output logic                                packet_overflow,
    output logic                                byte_skipped,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ps2mc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ps2mc_pkg::DIM_W-1:0]         cfg_data
);

    typedef enum logic [1:0]
    {
        PH_HEADER = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } phase_t;

    phase_t                                phase_reg, phase_next;
    logic [ps2mc_pkg::BYTE_W-1:0]          header_reg, header_next;
    logic [ps2mc_pkg::BYTE_W-1:0]          xdelta_reg, xdelta_next;
    logic [ps2mc_pkg::COORD_W-1:0]         cursor_x_reg, cursor_x_next;
    logic [ps2mc_pkg::COORD_W-1:0]         cursor_y_reg, cursor_y_next;
    logic [ps2mc_pkg::BTN_W-1:0]           buttons_reg, buttons_next;
    logic [ps2mc_pkg::DIM_W-1:0]           width_reg;
    logic [ps2mc_pkg::DIM_W-1:0]           height_reg;
    logic                                  out_valid_reg;
    logic [ps2mc_pkg::COORD_W-1:0]         pos_x_reg;
    logic [ps2mc_pkg::COORD_W-1:0]         pos_y_reg;
    logic [ps2mc_pkg::BTN_W-1:0]           btn_out_reg;
    logic                                  applied_reg, applied_next;
    logic                                  overflow_reg, overflow_next;
    logic                                  skipped_reg, skipped_next;

    logic                                  in_accept;
    logic signed [ps2mc_pkg::SUM_W-1:0]    dx;
    logic signed [ps2mc_pkg::SUM_W-1:0]    dy;
    logic signed [ps2mc_pkg::SUM_W-1:0]    sum_x;
    logic signed [ps2mc_pkg::SUM_W-1:0]    sum_y;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Nine-bit deltas: the sign bit from the header extends the data byte.
    assign dx = $signed({{(ps2mc_pkg::SUM_W-ps2mc_pkg::BYTE_W){header_reg[ps2mc_pkg::BIT_XSIGN]}},
                         xdelta_reg});
    assign dy = $signed({{(ps2mc_pkg::SUM_W-ps2mc_pkg::BYTE_W){header_reg[ps2mc_pkg::BIT_YSIGN]}},
                         rx_byte});
    assign sum_x = $signed({2'b00, cursor_x_reg}) + dx;
    assign sum_y = $signed({2'b00, cursor_y_reg}) - dy;

    always_comb
    begin
        phase_next    = phase_reg;
        header_next   = header_reg;
        xdelta_next   = xdelta_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        buttons_next  = buttons_reg;
        applied_next  = 1'b0;
        overflow_next = 1'b0;
        skipped_next  = 1'b0;
        unique case (phase_reg)
            PH_XDELTA:
            begin
                xdelta_next = rx_byte;
                phase_next  = PH_YDELTA;
            end
            PH_YDELTA:
            begin
                phase_next = PH_HEADER;
                if (header_reg[ps2mc_pkg::BIT_XOVF] || header_reg[ps2mc_pkg::BIT_YOVF])
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    cursor_x_next = ps2mc_pkg::clamp_coord(sum_x,
                                        ps2mc_pkg::max_coord(width_reg));
                    cursor_y_next = ps2mc_pkg::clamp_coord(sum_y,
                                        ps2mc_pkg::max_coord(height_reg));
                    buttons_next  = header_reg[ps2mc_pkg::BIT_LEFT +: ps2mc_pkg::BTN_W];
                    applied_next  = 1'b1;
                end
            end
            default:
            begin
                // Waiting for a header: a byte without the sync bit is dropped.
                if (!rx_byte[ps2mc_pkg::BIT_SYNC])
                begin
                    skipped_next = 1'b1;
                    phase_next   = PH_HEADER;
                end
                else
                begin
                    header_next = rx_byte;
                    phase_next  = PH_XDELTA;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            header_reg    <= '0;
            xdelta_reg    <= '0;
            cursor_x_reg  <= ps2mc_pkg::RESET_CURSOR_X;
            cursor_y_reg  <= ps2mc_pkg::RESET_CURSOR_Y;
            buttons_reg   <= '0;
            width_reg     <= ps2mc_pkg::RESET_WIDTH;
            height_reg    <= ps2mc_pkg::RESET_HEIGHT;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            btn_out_reg   <= '0;
            applied_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            skipped_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ps2mc_pkg::REG_SCREEN_WIDTH)
                begin
                    width_reg <= cfg_data;
                end
                else if (cfg_index == ps2mc_pkg::REG_SCREEN_HEIGHT)
                begin
                    height_reg <= cfg_data;
                end
            end
            if (in_accept)
            begin
                phase_reg     <= phase_next;
                header_reg    <= header_next;
                xdelta_reg    <= xdelta_next;
                cursor_x_reg  <= cursor_x_next;
                cursor_y_reg  <= cursor_y_next;
                buttons_reg   <= buttons_next;
                out_valid_reg <= 1'b1;
                pos_x_reg     <= cursor_x_next;
                pos_y_reg     <= cursor_y_next;
                btn_out_reg   <= buttons_next;
                applied_reg   <= applied_next;
                overflow_reg  <= overflow_next;
                skipped_reg   <= skipped_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign pos_x           = pos_x_reg;
    assign pos_y           = pos_y_reg;
    assign button_bits     = btn_out_reg;
    assign packet_applied  = applied_reg;
    assign packet_overflow = overflow_reg;
    assign byte_skipped    = skipped_reg;

endmodule

// File: rtl/core/ps2mc_checker.sv
// ----------------------------------------------------------------------------
// ps2mc_checker
// Port-level checks on the mouse packet decoder, bound to the core module.
// ----------------------------------------------------------------------------
module ps2mc_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [ps2mc_pkg::COORD_W-1:0]       pos_x,
    input  logic [ps2mc_pkg::COORD_W-1:0]       pos_y,
    input  logic [ps2mc_pkg::BTN_W-1:0]         button_bits,
    input  logic                                packet_applied,
    input  logic                                packet_overflow,
    input  logic                                byte_skipped
);

    // At most one status flag describes a single byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({packet_applied, packet_overflow, byte_skipped}))
    else $error("more than one status flag set on a result");

    // Every accepted byte shows its result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
    else $error("accepted byte produced no result");

    // A stalled result blocks further input, so no result is overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while a result was stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(pos_x) && $stable(pos_y) && $stable(button_bits)))
    else $error("stalled result changed");

endmodule

bind ps2_mouse_packet_cursor_core ps2mc_checker u_ps2mc_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .button_bits     (button_bits),
    .packet_applied  (packet_applied),
    .packet_overflow (packet_overflow),
    .byte_skipped    (byte_skipped)
);
